### design/tilt_complementary_filter_unit_defines.svh
// Assertion macros shared by the tilt filter RTL.
`ifndef TILT_COMPLEMENTARY_FILTER_UNIT_DEFINES_SVH
`define TILT_COMPLEMENTARY_FILTER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define TCF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tcf assertion failed");

`define TCF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tcf assertion failed");

`else

`define TCF_ASSERT_IMP(label, clk, rst_n, ante, cons)

`define TCF_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

### design/tcf_pkg.sv
package tcf_pkg;

    localparam int CORDIC_STEPS   = 16;
    localparam int ATAN_TABLE_LEN = 24;
    localparam int CORDIC_ITERS   = (CORDIC_STEPS > ATAN_TABLE_LEN) ? ATAN_TABLE_LEN
                                                                    : CORDIC_STEPS;
    localparam int ATAN_IDX_W     = $clog2(ATAN_TABLE_LEN);

    localparam int SAMPLE_W        = 16;
    localparam int SAMPLE_XW       = SAMPLE_W + 1;
    localparam int ANGLE_W         = 19;
    localparam int A16_W           = 20;
    localparam int CORDIC_XW       = 34;
    localparam int CORDIC_ACC_W    = 28;
    localparam int CORDIC_PRESHIFT = 14;
    localparam int Q24_TO_Q16      = 8;
    localparam int WEIGHT_W        = 16;
    localparam int GAIN_W          = 24;
    localparam int CFG_DATA_W      = 24;
    localparam int CFG_IDX_W       = 1;

    localparam logic signed [CORDIC_ACC_W-1:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [CORDIC_ACC_W-1:0] Q24_ROUND   =
        CORDIC_ACC_W'(1) <<< (Q24_TO_Q16 - 1);

    localparam logic [WEIGHT_W-1:0] BLEND_WEIGHT_RESET   = 16'd64225;
    localparam logic [GAIN_W-1:0]   GYRO_STEP_GAIN_RESET = 24'd11993847;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BLEND_WEIGHT   = 1'b0,
        CFG_GYRO_STEP_GAIN = 1'b1
    } t_cfg_idx;

    function automatic logic signed [CORDIC_ACC_W-1:0] atan_q24(
        input logic [ATAN_IDX_W-1:0] idx
    );
        logic signed [CORDIC_ACC_W-1:0] v;
        case (idx)
            5'd0:    v = 28'sd13176795;
            5'd1:    v = 28'sd7778716;
            5'd2:    v = 28'sd4110060;
            5'd3:    v = 28'sd2086331;
            5'd4:    v = 28'sd1047214;
            5'd5:    v = 28'sd524117;
            5'd6:    v = 28'sd262123;
            5'd7:    v = 28'sd131069;
            5'd8:    v = 28'sd65536;
            5'd9:    v = 28'sd32768;
            5'd10:   v = 28'sd16384;
            5'd11:   v = 28'sd8192;
            5'd12:   v = 28'sd4096;
            5'd13:   v = 28'sd2048;
            5'd14:   v = 28'sd1024;
            5'd15:   v = 28'sd512;
            5'd16:   v = 28'sd256;
            5'd17:   v = 28'sd128;
            5'd18:   v = 28'sd64;
            5'd19:   v = 28'sd32;
            5'd20:   v = 28'sd16;
            5'd21:   v = 28'sd8;
            5'd22:   v = 28'sd4;
            5'd23:   v = 28'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

### design/tcf_sample_if.sv
interface tcf_sample_if import tcf_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] accel_y;
    logic signed [SAMPLE_W-1:0] accel_z;
    logic signed [SAMPLE_W-1:0] gyro_rate;

    modport source (output valid, output accel_y, output accel_z, output gyro_rate,
                    input ready);
    modport sink (input valid, input accel_y, input accel_z, input gyro_rate,
                  output ready);
endinterface

### design/tcf_angle_if.sv
interface tcf_angle_if import tcf_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [ANGLE_W-1:0] tilt_angle;

    modport source (output valid, output tilt_angle, input ready);
    modport sink (input valid, input tilt_angle, output ready);
endinterface

### design/tilt_complementary_filter_unit.sv
// Tilt complementary filter. Each sample item yields one fused tilt angle in radians
// (Q2.16, saturated): the accelerometer tilt atan2(-accel_z, accel_y) from a 16-step
// vectoring CORDIC is blended with the kept angle plus gyro_step_gain times gyro_rate,
// weighted by blend_weight. After acceptance an item runs through the CORDIC's shift-add unit,
// then four passes through one 25 x 18 multiplier and the sums of their products, is rounded
// and saturated, and is loaded into the output register once that is free; only then is the
// next sample accepted.
// The result sits in an output register, so the next sample is taken while it waits.
// Write the registers only while no sample is in progress.
`include "tilt_complementary_filter_unit_defines.svh"

module tilt_complementary_filter_unit import tcf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    tcf_sample_if.sink            i_sample,
    tcf_angle_if.source           o_tilt
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CORDIC,
        S_MUL_A,
        S_MUL_G,
        S_PRED,
        S_MUL_LO,
        S_MUL_HI,
        S_ACC_HI,
        S_ROUND,
        S_OUT
    } t_state;

    localparam int MUL_A_W   = 25;
    localparam int MUL_B_W   = 18;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int PRED_W    = 45;
    localparam int PRED_LO_W = 24;
    localparam int SUM_W     = 64;
    localparam int SUM_SHIFT = 24;
    localparam int BLEND_SH  = 40;
    localparam int RES_W     = SUM_W - BLEND_SH;

    localparam logic signed [SUM_W-1:0] BLEND_ROUND = SUM_W'(1) <<< (BLEND_SH - 1);
    localparam logic signed [RES_W-1:0] RES_MAX     = RES_W'((1 << (ANGLE_W - 1)) - 1);
    localparam logic signed [RES_W-1:0] RES_MIN     = -RES_W'(1 << (ANGLE_W - 1));
    localparam logic [WEIGHT_W:0]       WEIGHT_ONE  = (WEIGHT_W + 1)'(1 << WEIGHT_W);

    t_state                     r_state;
    logic [WEIGHT_W-1:0]        r_weight;
    logic [GAIN_W-1:0]          r_gain;
    logic signed [ANGLE_W-1:0]  r_fused;
    logic signed [SAMPLE_W-1:0] r_gr;
    logic signed [A16_W-1:0]    r_a16;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [PRED_W-1:0]   r_pred;
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [ANGLE_W-1:0]  r_res;
    logic                       r_out_valid;
    logic signed [ANGLE_W-1:0]  r_out_data;

    logic                        accept;
    logic                        cordic_done;
    logic signed [A16_W-1:0]     cordic_angle;
    logic signed [SAMPLE_XW-1:0] cordic_y;
    logic [WEIGHT_W:0]           one_minus_w;
    logic signed [MUL_A_W-1:0]   mul_a;
    logic signed [MUL_B_W-1:0]   mul_b;
    logic signed [SUM_W-1:0]     rnd_sum;
    logic signed [RES_W-1:0]     res_wide;
    logic signed [ANGLE_W-1:0]   res_sat;
    logic                        out_free;

    assign accept          = i_sample.valid && i_sample.ready;
    assign i_sample.ready  = (r_state == S_IDLE);
    assign o_tilt.valid    = r_out_valid;
    assign o_tilt.tilt_angle = r_out_data;
    assign out_free        = !r_out_valid || o_tilt.ready;
    assign cordic_y        = -SAMPLE_XW'(i_sample.accel_z);

    tcf_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (accept),
        .i_x     (SAMPLE_XW'(i_sample.accel_y)),
        .i_y     (cordic_y),
        .o_done  (cordic_done),
        .o_angle (cordic_angle)
    );

    always_comb begin
        one_minus_w = WEIGHT_ONE - {1'b0, r_weight};
        case (r_state)
            S_MUL_A: begin
                mul_a = MUL_A_W'(r_a16);
                mul_b = $signed({1'b0, one_minus_w});
            end
            S_MUL_G: begin
                mul_a = $signed({1'b0, r_gain});
                mul_b = MUL_B_W'(r_gr);
            end
            S_MUL_LO: begin
                mul_a = $signed({1'b0, r_pred[PRED_LO_W-1:0]});
                mul_b = $signed({2'b00, r_weight});
            end
            S_MUL_HI: begin
                mul_a = MUL_A_W'($signed(r_pred[PRED_W-1:PRED_LO_W]));
                mul_b = $signed({2'b00, r_weight});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        rnd_sum  = r_sum + BLEND_ROUND;
        res_wide = rnd_sum[SUM_W-1:BLEND_SH];
        if (res_wide > RES_MAX) begin
            res_sat = ANGLE_W'(RES_MAX);
        end else if (res_wide < RES_MIN) begin
            res_sat = ANGLE_W'(RES_MIN);
        end else begin
            res_sat = ANGLE_W'(res_wide);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= BLEND_WEIGHT_RESET;
            r_gain   <= GYRO_STEP_GAIN_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_BLEND_WEIGHT:   r_weight <= i_cfg_data[WEIGHT_W-1:0];
                CFG_GYRO_STEP_GAIN: r_gain   <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fused     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_tilt.valid && o_tilt.ready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_gr    <= i_sample.gyro_rate;
                        r_state <= S_CORDIC;
                    end
                end
                S_CORDIC: begin
                    if (cordic_done) begin
                        r_a16   <= cordic_angle;
                        r_state <= S_MUL_A;
                    end
                end
                S_MUL_A: begin
                    r_state <= S_MUL_G;
                end
                S_MUL_G: begin
                    r_sum   <= SUM_W'(r_prod) <<< SUM_SHIFT;
                    r_state <= S_PRED;
                end
                S_PRED: begin
                    r_pred  <= (PRED_W'(r_fused) <<< SUM_SHIFT) + PRED_W'(r_prod);
                    r_state <= S_MUL_LO;
                end
                S_MUL_LO: begin
                    r_state <= S_MUL_HI;
                end
                S_MUL_HI: begin
                    r_sum   <= r_sum + SUM_W'(r_prod);
                    r_state <= S_ACC_HI;
                end
                S_ACC_HI: begin
                    r_sum   <= r_sum + (SUM_W'(r_prod) <<< SUM_SHIFT);
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_res   <= res_sat;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_data  <= r_res;
                        r_out_valid <= 1'b1;
                        r_fused     <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `TCF_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, accept, !i_sample.ready)
    `TCF_ASSERT_IMP(a_done_while_waiting, i_clk, i_rst_n, cordic_done, r_state == S_CORDIC)
    `TCF_ASSERT_IMP(a_out_matches_state, i_clk, i_rst_n, r_out_valid, r_out_data == r_fused)
    `TCF_ASSERT_NXT(a_result_loaded, i_clk, i_rst_n, (r_state == S_OUT) && out_free,
                    r_out_valid && (r_state == S_IDLE))

endmodule

### design/tcf_cordic.sv
`include "tilt_complementary_filter_unit_defines.svh"

module tcf_cordic import tcf_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic signed [SAMPLE_XW-1:0] i_x,
    input  logic signed [SAMPLE_XW-1:0] i_y,
    output logic                        o_done,
    output logic signed [A16_W-1:0]     o_angle
);

    typedef enum logic [1:0] {
        C_IDLE,
        C_RUN,
        C_ROUND
    } t_state;

    localparam logic [ATAN_IDX_W-1:0] LAST_STEP = ATAN_IDX_W'(CORDIC_ITERS - 1);

    t_state                         r_state;
    logic [ATAN_IDX_W-1:0]          r_cnt;
    logic                           r_zero;
    logic signed [CORDIC_XW-1:0]    r_x, r_y;
    logic signed [CORDIC_ACC_W-1:0] r_acc;

    logic signed [CORDIC_XW-1:0]    sx, sy, x0, y0, dx, dy, n_x, n_y;
    logic signed [CORDIC_ACC_W-1:0] acc0, n_acc, rnd;
    logic                           zero_in;

    always_comb begin
        sx      = CORDIC_XW'(i_x) <<< CORDIC_PRESHIFT;
        sy      = CORDIC_XW'(i_y) <<< CORDIC_PRESHIFT;
        zero_in = (i_x == '0) && (i_y == '0);
        if (sx < 0) begin
            if (sy >= 0) begin
                x0   = sy;
                y0   = -sx;
                acc0 = HALF_PI_Q24;
            end else begin
                x0   = -sy;
                y0   = sx;
                acc0 = -HALF_PI_Q24;
            end
        end else begin
            x0   = sx;
            y0   = sy;
            acc0 = '0;
        end
    end

    always_comb begin
        dx = r_y >>> r_cnt;
        dy = r_x >>> r_cnt;
        if (!r_y[CORDIC_XW-1]) begin
            n_x   = r_x + dx;
            n_y   = r_y - dy;
            n_acc = r_acc + atan_q24(r_cnt);
        end else begin
            n_x   = r_x - dx;
            n_y   = r_y + dy;
            n_acc = r_acc - atan_q24(r_cnt);
        end
        rnd = r_acc + Q24_ROUND;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_state)
                C_IDLE: begin
                    if (i_start) begin
                        r_x     <= x0;
                        r_y     <= y0;
                        r_acc   <= acc0;
                        r_zero  <= zero_in;
                        r_cnt   <= '0;
                        r_state <= C_RUN;
                    end
                end
                C_RUN: begin
                    r_x   <= n_x;
                    r_y   <= n_y;
                    r_acc <= n_acc;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == LAST_STEP) begin
                        r_state <= C_ROUND;
                    end
                end
                C_ROUND: begin
                    o_angle <= r_zero ? '0 : rnd[CORDIC_ACC_W-1:CORDIC_ACC_W-A16_W];
                    o_done  <= 1'b1;
                    r_state <= C_IDLE;
                end
                default: begin
                    r_state <= C_IDLE;
                end
            endcase
        end
    end

    `TCF_ASSERT_IMP(a_start_when_idle, i_clk, i_rst_n, i_start, r_state == C_IDLE)
    `TCF_ASSERT_IMP(a_x_nonneg, i_clk, i_rst_n, r_state == C_RUN, !r_x[CORDIC_XW-1])
    `TCF_ASSERT_IMP(a_done_to_idle, i_clk, i_rst_n, o_done, r_state == C_IDLE)

endmodule

### sim/tilt_complementary_filter_unit_tb.sv
module tilt_complementary_filter_unit_tb;
    import tcf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint ATAN_STEP_Q24 [24] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };
    localparam longint QUARTER_TURN_Q24 = 26353589;
    localparam longint ANGLE_HI = 262143;
    localparam longint ANGLE_LO = -262144;
    localparam int SETTLE_CYCLES = 40;

    class angle_tracker;
        longint weight;
        longint gain;
        longint fused;
        logic signed [ANGLE_W-1:0] pending_angles[$];
        int mismatches;

        function new();
            weight = longint'(BLEND_WEIGHT_RESET);
            gain = longint'(GYRO_STEP_GAIN_RESET);
            fused = 0;
            mismatches = 0;
        endfunction

        function longint accel_tilt(longint xv, longint yv);
            longint x, y, t, acc, dx, dy;
            acc = 0;
            if (xv == 0 && yv == 0) begin
                return 0;
            end
            x = xv * 16384;
            y = yv * 16384;
            if (x < 0) begin
                t = x;
                if (y >= 0) begin
                    x = y;
                    y = -t;
                    acc = QUARTER_TURN_Q24;
                end else begin
                    x = -y;
                    y = t;
                    acc = -QUARTER_TURN_Q24;
                end
            end
            for (int i = 0; i < CORDIC_ITERS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x = x + dx;
                    y = y - dy;
                    acc = acc + ATAN_STEP_Q24[i];
                end else begin
                    x = x - dx;
                    y = y + dy;
                    acc = acc - ATAN_STEP_Q24[i];
                end
            end
            return (acc + 128) >>> 8;
        endfunction

        function void note_sample(logic signed [SAMPLE_W-1:0] ay,
                                  logic signed [SAMPLE_W-1:0] az,
                                  logic signed [SAMPLE_W-1:0] gr);
            longint a16, pred, sum, res;
            a16 = accel_tilt(longint'(ay), -longint'(az));
            pred = fused * 64'sd16777216 + gain * longint'(gr);
            sum = (64'sd65536 - weight) * a16 * 64'sd16777216 + weight * pred;
            res = (sum + (64'sd1 <<< 39)) >>> 40;
            if (res > ANGLE_HI) begin
                res = ANGLE_HI;
            end
            if (res < ANGLE_LO) begin
                res = ANGLE_LO;
            end
            fused = res;
            pending_angles.push_back(ANGLE_W'(res));
        endfunction

        function void check_angle(logic signed [ANGLE_W-1:0] got);
            logic signed [ANGLE_W-1:0] want;
            if (pending_angles.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected tilt_angle %0d with no item pending", got);
                end
                return;
            end
            want = pending_angles.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("tilt_angle mismatch: expected %0d, actual %0d", want, got);
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    bit quiet;
    angle_tracker tracker;

    tcf_sample_if smp();
    tcf_angle_if ang();

    tilt_complementary_filter_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_sample   (smp),
        .o_tilt     (ang)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #15_000_000;
        $display("Some tests failed");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && ang.valid === 1'b1 && ang.ready === 1'b1) begin
            tracker.check_angle(ang.tilt_angle);
        end
    end

    initial begin
        ang.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (!quiet && $urandom_range(0, 3) == 0) begin
                ang.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end else begin
                ang.ready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
            end
        end
    end

    task automatic set_filter(logic [WEIGHT_W-1:0] w, logic [GAIN_W-1:0] g);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_BLEND_WEIGHT;
        i_cfg_data <= CFG_DATA_W'(w);
        @(posedge i_clk);
        i_cfg_idx <= CFG_GYRO_STEP_GAIN;
        i_cfg_data <= g;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        tracker.weight = longint'(w);
        tracker.gain = longint'(g);
    endtask

    task automatic send_sample(logic signed [SAMPLE_W-1:0] ay,
                               logic signed [SAMPLE_W-1:0] az,
                               logic signed [SAMPLE_W-1:0] gr);
        smp.valid <= 1'b1;
        smp.accel_y <= ay;
        smp.accel_z <= az;
        smp.gyro_rate <= gr;
        @(posedge i_clk);
        while (smp.ready !== 1'b1) @(posedge i_clk);
        tracker.note_sample(ay, az, gr);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            smp.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        smp.valid <= 1'b0;
        while (tracker.pending_angles.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] rand_axis();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 4))
                    0: return -16'sd32768;
                    1: return 16'sd32767;
                    2: return 16'sd0;
                    3: return -16'sd1;
                    default: return 16'sd1;
                endcase
            end
            1, 2: return SAMPLE_W'(int'($urandom_range(0, 400)) - 200);
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    task automatic run_random(int count);
        int drift_left;
        logic signed [SAMPLE_W-1:0] drift_rate;
        logic signed [SAMPLE_W-1:0] gr;
        drift_left = 0;
        drift_rate = '0;
        for (int n = 0; n < count; n++) begin
            if (drift_left == 0 && $urandom_range(0, 19) == 0) begin
                drift_left = $urandom_range(5, 15);
                drift_rate = SAMPLE_W'($urandom_range(20000, 32767));
                if ($urandom_range(0, 1) == 1) begin
                    drift_rate = -drift_rate - 16'sd1;
                end
            end
            if (drift_left > 0) begin
                gr = drift_rate;
                drift_left--;
            end else begin
                gr = rand_axis();
            end
            send_sample(rand_axis(), rand_axis(), gr);
        end
    endtask

    initial begin
        tracker = new();
        quiet = 1'b0;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= CFG_BLEND_WEIGHT;
        i_cfg_data <= '0;
        smp.valid <= 1'b0;
        smp.accel_y <= '0;
        smp.accel_z <= '0;
        smp.gyro_rate <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero vector, the axes, the negative Y axis and all four corners first.
        send_sample(16'sd0, 16'sd0, 16'sd0);
        send_sample(16'sd32767, 16'sd0, 16'sd0);
        send_sample(-16'sd32768, 16'sd0, 16'sd0);
        send_sample(16'sd0, -16'sd32768, 16'sd0);
        send_sample(16'sd0, 16'sd32767, 16'sd0);
        send_sample(-16'sd32768, -16'sd32768, 16'sd0);
        send_sample(-16'sd32768, 16'sd32767, 16'sd0);
        send_sample(16'sd32767, 16'sd32767, 16'sd0);
        send_sample(16'sd32767, -16'sd32768, 16'sd0);
        send_sample(-16'sd1, 16'sd0, 16'sd0);
        send_sample(-16'sd1, -16'sd1, 16'sd0);
        send_sample(16'sd1, 16'sd1, 16'sd0);
        send_sample(16'sd0, 16'sd0, 16'sd32767);
        send_sample(16'sd0, 16'sd0, 16'sd32767);
        send_sample(16'sd0, 16'sd0, 16'sd32767);
        send_sample(16'sd0, 16'sd0, -16'sd32768);
        send_sample(16'sd0, 16'sd0, -16'sd32768);
        send_sample(16'sd0, 16'sd0, -16'sd32768);
        send_sample(-16'sd32768, 16'sd0, 16'sd32767);
        send_sample(16'sd100, -16'sd16384, -16'sd1234);
        wait_drained();

        set_filter(16'd0, 24'hFFFFFF);
        run_random(200);
        wait_drained();

        set_filter(16'hFFFF, 24'd0);
        run_random(150);
        wait_drained();

        set_filter(16'hFFFF, 24'hFFFFFF);
        run_random(200);
        wait_drained();

        for (int k = 0; k < 3; k++) begin
            set_filter(WEIGHT_W'($urandom()), GAIN_W'($urandom()));
            run_random(150);
            wait_drained();
        end

        set_filter(BLEND_WEIGHT_RESET, GYRO_STEP_GAIN_RESET);
        quiet = 1'b1;
        run_random(150);
        wait_drained();

        if (tracker.mismatches == 0 && tracker.pending_angles.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
